// ----- hdl/pete_pkg.sv -----
// shared types and constants of the pulse edge timing extractor
// no dependencies

package pete_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int POSITION_BITS  = 48;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = SAMPLE_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_THRESHOLD = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALIGN_MODE      = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_LEVEL     = CSR_INDEX_BITS'(2);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [POSITION_BITS-1:0]      position_type;

   typedef struct packed {
      sample_type level_threshold;
      logic       align_mode;
   } cfg_type;

   typedef struct packed {
      logic align_we;
      logic start_we;
      logic value;
   } cfg_load_type;

   typedef struct packed {
      sample_type   sample_value;
      position_type sample_position;
      logic         restart;
   } item_type;

endpackage

// ----- hdl/pete_req_if.sv -----
// sample input channel: valid/ready handshake with sample payload
// depends on pete_pkg

interface pete_req_if;
   import pete_pkg::*;

   logic         valid;
   logic         ready;
   sample_type   sample_value;
   position_type sample_position;
   logic         restart;

   modport source (output valid, sample_value, sample_position, restart, input ready);
   modport sink (input valid, sample_value, sample_position, restart, output ready);
   modport monitor (input valid, ready, sample_value, sample_position, restart);
endinterface

// ----- hdl/pete_rsp_if.sv -----
// pulse result channel: valid/ready handshake with pulse timing payload
// depends on pete_pkg

interface pete_rsp_if;
   import pete_pkg::*;

   logic         valid;
   logic         ready;
   position_type pulse_start;
   position_type pulse_middle;
   position_type pulse_end;
   logic         end_level;

   modport source (output valid, pulse_start, pulse_middle, pulse_end, end_level,
                   input ready);
   modport sink (input valid, pulse_start, pulse_middle, pulse_end, end_level,
                 output ready);
   modport monitor (input valid, ready, pulse_start, pulse_middle, pulse_end, end_level);
endinterface

// ----- hdl/pete_csr_if.sv -----
// register write channel: valid/ready handshake with index and data
// depends on pete_pkg

interface pete_csr_if;
   import pete_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

// ----- hdl/pulse_edge_timing_extractor.sv -----
// top level: register stage, edge unit with result register, register file
// a sample beat passes from the input register to the result register
// throughput: one sample per clock while the result channel does not stall; the edge state is registered
// a stalled result blocks new samples only once the input register is also full
// synchronous active-high reset: empty pipeline, thresholds and modes zero,
// previous level low, edge level high, stored positions zero

module pulse_edge_timing_extractor (
   input  logic      clock,
   input  logic      reset,
   pete_req_if.sink  req_ch,
   pete_rsp_if.source rsp_ch,
   pete_csr_if.sink  csr_ch
);
   import pete_pkg::*;

   cfg_type      cfg;
   cfg_load_type load;
   logic         advance;
   logic         item_valid;
   item_type     item;

   pete_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg),
      .load   (load)
   );

   pete_stage u_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pete_edge u_edge (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .load       (load),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_ch     (rsp_ch)
   );
endmodule

// ----- hdl/pete_csr.sv -----
// configuration registers and load strobes for the edge state
// depends on pete_pkg and pete_csr_if

module pete_csr (
   input  logic                  clock,
   input  logic                  reset,
   pete_csr_if.sink              csr_ch,
   output pete_pkg::cfg_type      cfg,
   output pete_pkg::cfg_load_type load
);
   import pete_pkg::*;

   sample_type threshold_ff, threshold_in;
   logic       align_ff, align_in;
   logic       wr_beat;

   assign csr_ch.ready = 1'b1;
   assign wr_beat      = csr_ch.valid;

   always_comb begin
      threshold_in  = threshold_ff;
      align_in      = align_ff;
      load.align_we = 1'b0;
      load.start_we = 1'b0;
      load.value    = csr_ch.data[0];
      if (wr_beat) begin
         unique case (csr_ch.index)
            CSR_LEVEL_THRESHOLD: threshold_in = sample_type'(csr_ch.data[SAMPLE_BITS-1:0]);
            CSR_ALIGN_MODE: begin
               align_in      = csr_ch.data[0];
               load.align_we = 1'b1;
            end
            CSR_START_LEVEL: load.start_we = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         align_ff     <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         align_ff     <= align_in;
      end
   end

   assign cfg.level_threshold = threshold_ff;
   assign cfg.align_mode      = align_ff;
endmodule

// ----- hdl/pete_stage.sv -----
// input register stage holding one sample beat
// depends on pete_pkg and pete_req_if

module pete_stage (
   input  logic              clock,
   input  logic              reset,
   pete_req_if.sink          req_ch,
   input  logic              advance,
   output logic              item_valid,
   output pete_pkg::item_type item
);
   import pete_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.sample_value    <= req_ch.sample_value;
         item_ff.sample_position <= req_ch.sample_position;
         item_ff.restart         <= req_ch.restart;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

// ----- hdl/pete_edge.sv -----
// level compare, edge state and pulse check with the result register
// depends on pete_pkg and pete_rsp_if

module pete_edge (
   input  logic                   clock,
   input  logic                   reset,
   input  pete_pkg::cfg_type      cfg,
   input  pete_pkg::cfg_load_type load,
   input  logic                   item_valid,
   input  pete_pkg::item_type     item,
   output logic                   advance,
   pete_rsp_if.source             rsp_ch
);
   import pete_pkg::*;

   logic         prev_ff, prev_in;
   logic         edge_ff, edge_in;
   position_type rise_ff, rise_in;
   position_type fall_ff, fall_in;
   logic         out_valid_ff, out_valid_in;
   position_type start_ff, middle_ff, end_ff;
   logic         level_ff;

   position_type pos, rise_cur, fall_cur, first_pos, middle_pos;
   logic         level, changed, closing, emit, fire;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign fire    = item_valid && advance;

   // restart applies before the sample is looked at
   always_comb begin
      pos        = item.sample_position;
      rise_cur   = item.restart ? pos : rise_ff;
      fall_cur   = item.restart ? pos : fall_ff;
      level      = ($signed(item.sample_value) >= $signed(cfg.level_threshold));
      changed    = (level != prev_ff);
      first_pos  = level ? rise_cur : fall_cur;
      middle_pos = level ? fall_cur : rise_cur;
      closing    = (level != edge_ff) && (level != cfg.align_mode) && (rise_cur != fall_cur);
      emit       = changed && closing && (pos > middle_pos) && (middle_pos > first_pos);
   end

   always_comb begin
      prev_in = prev_ff;
      edge_in = edge_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      if (fire) begin
         rise_in = (changed && level) ? pos : rise_cur;
         fall_in = (changed && !level) ? pos : fall_cur;
         if (changed) begin
            prev_in = level;
            edge_in = level;
         end
      end
      if (load.start_we) begin
         prev_in = load.value;
      end
      if (load.align_we) begin
         edge_in = !load.value;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= 1'b0;
         edge_ff      <= 1'b1;
         rise_ff      <= '0;
         fall_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         edge_ff      <= edge_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         start_ff  <= first_pos;
         middle_ff <= middle_pos;
         end_ff    <= pos;
         level_ff  <= level;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.pulse_start  = start_ff;
   assign rsp_ch.pulse_middle = middle_ff;
   assign rsp_ch.pulse_end    = end_ff;
   assign rsp_ch.end_level    = level_ff;
endmodule

// ----- hdl/pete_checker.sv -----
// port-level checks on the pulse edge timing extractor, bound to the top level
// depends on pete_pkg and the handshake ports of the top level

module pete_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input pete_pkg::position_type rsp_pulse_start,
   input pete_pkg::position_type rsp_pulse_middle,
   input pete_pkg::position_type rsp_pulse_end,
   input logic                   rsp_end_level,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_start)
         && $stable(rsp_pulse_middle) && $stable(rsp_pulse_end)
         && $stable(rsp_end_level))
      else $error("result beat changed while stalled");

   // emitted pulse positions strictly increase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pulse_start < rsp_pulse_middle)
         && (rsp_pulse_middle < rsp_pulse_end))
      else $error("pulse positions not increasing");

   // empty result register never stalls the sample input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // register writes are never back-pressured
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");
endmodule

bind pulse_edge_timing_extractor pete_checker u_pete_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_pulse_start  (rsp_ch.pulse_start),
   .rsp_pulse_middle (rsp_ch.pulse_middle),
   .rsp_pulse_end    (rsp_ch.pulse_end),
   .rsp_end_level    (rsp_ch.end_level),
   .csr_valid        (csr_ch.valid),
   .csr_ready        (csr_ch.ready)
);
